// ===== rtl/ffpa_pkg.sv =====
// Shared constants for the first-fit pool allocator: field widths,
// command and status codes, default sizes. No dependencies.
package ffpa_pkg;

  localparam int GRANULE_BYTES = 8;
  localparam int DEF_POOL_GRANULES = 4096;
  localparam int DEF_HEADER_BYTES = 24;

  localparam int CMD_W = 2;
  localparam int REQ_W = 20;
  localparam int ADDR_W = 15;
  localparam int STATUS_W = 3;
  localparam int COPY_W = 16;
  localparam int CFG_W = 16;
  localparam int NEED_W = 18;
  localparam int BYTE_W = 20;
  localparam int TDATA_W = 40;

  localparam logic [CFG_W-1:0] POOL_BYTES_RESET = 16'd32768;

  localparam logic [CMD_W-1:0] CMD_RESET_POOL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESIZE = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_BLOCK = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_RELEASED = 3'd4;

endpackage

// ===== rtl/ffpa_table.sv =====
// Block table memory: one write port, one read port with registered data.
// Depends on nothing.
module ffpa_table #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 14
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/first_fit_pool_allocator.sv =====
// First-fit pool allocator top level: stream ports, sequencer, block table walk.
// Depends on ffpa_pkg and ffpa_table.
// Search walks the block table through S_A_RD and S_A_CHK; merging walks it through
//   S_C_RD, S_C_CHK and S_C_MRG.
// One command at a time: input is taken only in the idle state.
// Reset and reset_pool clear the whole table through S_INIT and S_CLEAR, no input taken meanwhile.
module first_fit_pool_allocator #(
  parameter int POOL_GRANULES = ffpa_pkg::DEF_POOL_GRANULES,
  parameter int HEADER_BYTES = ffpa_pkg::DEF_HEADER_BYTES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ffpa_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // command[1:0], request_bytes[21:2], user_address[36:22], address_present[37]
  input  logic [ffpa_pkg::TDATA_W-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // status[2:0], result_address[17:3], result_valid[18], copy_bytes[34:19]
  output logic [ffpa_pkg::TDATA_W-1:0] m_tdata
);

  import ffpa_pkg::*;

  localparam int GW = $clog2(POOL_GRANULES);
  localparam int SW = GW + 1;
  localparam int HDR_G = (HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
  localparam int HDR_AL = HDR_G * GRANULE_BYTES;

  localparam logic [3:0] S_IDLE = 4'd0, S_INIT = 4'd1, S_CLEAR = 4'd2, S_A_RD = 4'd3,
                         S_A_CHK = 4'd4, S_A_SPLIT = 4'd5, S_L_RD = 4'd6, S_L_CHK = 4'd7,
                         S_REL = 4'd8, S_C_RD = 4'd9, S_C_CHK = 4'd10, S_C_MRG = 4'd11,
                         S_DONE = 4'd12;
  localparam logic [1:0] MODE_ALLOC = 2'd0, MODE_FREE = 2'd1, MODE_RESIZE = 2'd2;

  logic [3:0] state, state_next;
  logic [1:0] mode, mode_next;
  logic reply, reply_next;
  logic [CFG_W-1:0] pool_bytes;
  logic [SW-1:0] pg, pg_next;
  logic [GW-1:0] cnt, cnt_next;
  logic [SW-1:0] g, g_next;
  logic [GW-1:0] pidx, pidx_next;
  logic [SW-1:0] psize, psize_next;
  logic has_prev, has_prev_next;
  logic [GW-1:0] og, og_next;
  logic [SW-1:0] osize, osize_next;
  logic [NEED_W-1:0] need, need_next;
  logic [REQ_W-1:0] req, req_next;
  logic [ADDR_W-1:0] addr, addr_next;
  logic [STATUS_W-1:0] status, status_next;
  logic [ADDR_W-1:0] res, res_next;
  logic res_valid, res_valid_next;
  logic [COPY_W-1:0] copy, copy_next;

  logic we;
  logic [GW-1:0] waddr, raddr;
  logic [SW:0] wdata, rdata;

  ffpa_table #(.DEPTH(POOL_GRANULES), .WIDTH(SW + 1)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [CMD_W-1:0] in_cmd;
  logic [REQ_W-1:0] in_req;
  logic [ADDR_W-1:0] in_addr;
  logic in_present;
  assign in_cmd = s_tdata[1:0];
  assign in_req = s_tdata[21:2];
  assign in_addr = s_tdata[36:22];
  assign in_present = s_tdata[37];

  logic [SW-1:0] ent_size, rem, left;
  logic ent_free, ent_bad;
  assign ent_size = rdata[SW:1];
  assign ent_free = rdata[0];
  assign rem = pg - g;
  assign ent_bad = (ent_size == '0) || (ent_size > rem);
  assign left = ent_size - SW'(need);

  logic [REQ_W-1:0] r_eff;
  logic [REQ_W:0] r_round;
  logic [NEED_W-1:0] in_need;
  assign r_eff = (in_req == '0) ? REQ_W'(1) : in_req;
  assign r_round = {1'b0, r_eff} + (REQ_W + 1)'(GRANULE_BYTES - 1);
  assign in_need = r_round[REQ_W:3] + NEED_W'(HDR_G);

  logic [BYTE_W-1:0] pool_limit, in_addr_w, in_off, in_gran;
  assign pool_limit = BYTE_W'({pg, 3'b000});
  assign in_addr_w = BYTE_W'(in_addr);
  assign in_off = in_addr_w - BYTE_W'(HDR_AL);
  assign in_gran = in_off >> 3;

  logic [BYTE_W-1:0] found_addr, blk_bytes, blk_user_bytes, req_w, copy_w;
  assign found_addr = BYTE_W'({g, 3'b000}) + BYTE_W'(HDR_AL);
  assign blk_bytes = BYTE_W'({osize, 3'b000});
  assign blk_user_bytes = (blk_bytes >= BYTE_W'(HDR_AL)) ? blk_bytes - BYTE_W'(HDR_AL) : '0;
  assign req_w = BYTE_W'(req);
  assign copy_w = (blk_user_bytes < req_w) ? blk_user_bytes : req_w;

  function automatic logic [15:0] cfg_pool_round();
    logic [16:0] t;
    t = {1'b0, pool_bytes} + 17'd7;
    return {2'b00, t[16:3]};
  endfunction

  logic [16:0] pg_raw, pg_cap;
  assign pg_raw = {1'b0, cfg_pool_round()};
  assign pg_cap = (pg_raw == '0) ? 17'd1 :
                  (pg_raw > 17'(POOL_GRANULES)) ? 17'(POOL_GRANULES) : pg_raw;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    mode_next = mode;
    reply_next = reply;
    pg_next = pg;
    cnt_next = cnt;
    g_next = g;
    pidx_next = pidx;
    psize_next = psize;
    has_prev_next = has_prev;
    og_next = og;
    osize_next = osize;
    need_next = need;
    req_next = req;
    addr_next = addr;
    status_next = status;
    res_next = res;
    res_valid_next = res_valid;
    copy_next = copy;
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = g[GW-1:0];
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          status_next = STATUS_OK;
          res_next = '0;
          res_valid_next = 1'b0;
          copy_next = '0;
          req_next = in_req;
          addr_next = in_addr;
          need_next = in_need;
          g_next = '0;
          if (in_cmd == CMD_RESET_POOL) begin
            reply_next = 1'b1;
            state_next = S_INIT;
          end else if (in_cmd == CMD_ALLOC || (in_cmd == CMD_RESIZE && !in_present)) begin
            mode_next = MODE_ALLOC;
            state_next = S_A_RD;
          end else begin
            mode_next = (in_cmd == CMD_FREE || in_req == '0) ? MODE_FREE : MODE_RESIZE;
            if (!in_present) begin
              state_next = (in_cmd == CMD_FREE || in_req == '0) ? S_DONE : S_A_RD;
            end else if (in_addr_w >= pool_limit) begin
              status_next = STATUS_OUTSIDE;
              state_next = S_DONE;
            end else if (in_addr_w < BYTE_W'(HDR_AL) || in_addr[2:0] != 3'b000 ||
                         in_gran >= BYTE_W'(POOL_GRANULES)) begin
              status_next = STATUS_NOT_BLOCK;
              state_next = S_DONE;
            end else begin
              og_next = in_gran[GW-1:0];
              state_next = S_L_RD;
            end
          end
        end
      end
      S_INIT: begin
        pg_next = pg_cap[SW-1:0];
        cnt_next = '0;
        state_next = S_CLEAR;
      end
      S_CLEAR: begin
        we = 1'b1;
        waddr = cnt;
        wdata = (cnt == '0) ? {pg, 1'b1} : '0;
        cnt_next = cnt + 1'b1;
        if (cnt == GW'(POOL_GRANULES - 1)) begin
          state_next = reply ? S_DONE : S_IDLE;
        end
      end
      S_A_RD: begin
        if (g >= pg) begin
          status_next = STATUS_NO_SPACE;
          state_next = S_DONE;
        end else begin
          state_next = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (ent_bad) begin
          status_next = STATUS_NO_SPACE;
          state_next = S_DONE;
        end else if (ent_free && NEED_W'(ent_size) >= need) begin
          we = 1'b1;
          waddr = g[GW-1:0];
          if (left >= SW'(HDR_G + 1)) begin
            wdata = {SW'(need), 1'b0};
            psize_next = left;
            state_next = S_A_SPLIT;
          end else begin
            wdata = {ent_size, 1'b0};
            res_next = found_addr[ADDR_W-1:0];
            res_valid_next = 1'b1;
            if (mode == MODE_RESIZE) begin
              copy_next = copy_w[COPY_W-1:0];
              state_next = S_REL;
            end else begin
              state_next = S_DONE;
            end
          end
        end else begin
          g_next = g + ent_size;
          state_next = S_A_RD;
        end
      end
      S_A_SPLIT: begin
        we = 1'b1;
        waddr = GW'(g + SW'(need));
        wdata = {psize, 1'b1};
        res_next = found_addr[ADDR_W-1:0];
        res_valid_next = 1'b1;
        if (mode == MODE_RESIZE) begin
          copy_next = copy_w[COPY_W-1:0];
          state_next = S_REL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_L_RD: begin
        raddr = og;
        state_next = S_L_CHK;
      end
      S_L_CHK: begin
        if (ent_size == '0 || ent_free) begin
          status_next = STATUS_NOT_BLOCK;
          state_next = S_DONE;
        end else begin
          osize_next = ent_size;
          if (mode == MODE_FREE) begin
            status_next = STATUS_RELEASED;
            state_next = S_REL;
          end else if (need <= NEED_W'(ent_size)) begin
            res_next = addr;
            res_valid_next = 1'b1;
            state_next = S_DONE;
          end else begin
            g_next = '0;
            state_next = S_A_RD;
          end
        end
      end
      S_REL: begin
        we = 1'b1;
        waddr = og;
        wdata = {osize, 1'b1};
        g_next = '0;
        has_prev_next = 1'b0;
        state_next = S_C_RD;
      end
      S_C_RD: begin
        state_next = (g >= pg) ? S_DONE : S_C_CHK;
      end
      S_C_CHK: begin
        g_next = g + ent_size;
        if (ent_bad) begin
          g_next = g;
          state_next = S_DONE;
        end else if (ent_free) begin
          if (has_prev && (SW'(pidx) + psize) == g) begin
            we = 1'b1;
            waddr = g[GW-1:0];
            wdata = '0;
            psize_next = psize + ent_size;
            state_next = S_C_MRG;
          end else begin
            has_prev_next = 1'b1;
            pidx_next = g[GW-1:0];
            psize_next = ent_size;
            state_next = S_C_RD;
          end
        end else begin
          state_next = S_C_RD;
        end
      end
      S_C_MRG: begin
        we = 1'b1;
        waddr = pidx;
        wdata = {psize, 1'b1};
        state_next = S_C_RD;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      reply <= 1'b0;
      pool_bytes <= POOL_BYTES_RESET;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      reply <= (state == S_DONE) ? 1'b0 : reply_next;
      if (cfg_we) begin
        pool_bytes <= cfg_data;
      end
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode <= mode_next;
    pg <= pg_next;
    cnt <= cnt_next;
    g <= g_next;
    pidx <= pidx_next;
    psize <= psize_next;
    has_prev <= has_prev_next;
    og <= og_next;
    osize <= osize_next;
    need <= need_next;
    req <= req_next;
    addr <= addr_next;
    status <= status_next;
    res <= res_next;
    res_valid <= res_valid_next;
    copy <= copy_next;
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {5'b00000, copy, res_valid, res, status};
    end
  end

endmodule

// ===== tb/first_fit_pool_allocator_tb.sv =====
// Testbench for first_fit_pool_allocator: drives commands on the input stream,
// predicts each result with a block-table model and checks the output stream.
// Depends on ffpa_pkg and the allocator RTL.
`timescale 1ns / 100ps

module first_fit_pool_allocator_tb;
  import ffpa_pkg::*;

  localparam int NG = DEF_POOL_GRANULES;
  localparam int HG = (DEF_HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
  localparam int HB = HG * GRANULE_BYTES;
  localparam int IDLE_LIMIT = 200000;

  typedef struct packed {
    logic [COPY_W-1:0]   copy_bytes;
    logic                result_valid;
    logic [ADDR_W-1:0]   result_address;
    logic [STATUS_W-1:0] status;
  } alloc_result_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [TDATA_W-1:0] m_tdata;

  first_fit_pool_allocator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  int unsigned blk_size [NG];
  bit blk_free [NG];
  int unsigned pool_g;
  int unsigned pool_reg = POOL_BYTES_RESET;
  alloc_result_t pending_results[$];
  int unsigned live_addrs[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stall_out = 0;

  function automatic void rebuild_pool();
    int unsigned pg;
    pg = (pool_reg + GRANULE_BYTES - 1) / GRANULE_BYTES;
    if (pg == 0) pg = 1;
    if (pg > NG) pg = NG;
    foreach (blk_size[i]) begin
      blk_size[i] = 0;
      blk_free[i] = 0;
    end
    pool_g = pg;
    blk_size[0] = pg;
    blk_free[0] = 1;
  endfunction

  function automatic void merge_free();
    int unsigned g, p, s;
    bit has_p;
    g = 0;
    p = 0;
    has_p = 0;
    while (g < pool_g) begin
      s = blk_size[g];
      if (s == 0 || s > pool_g - g) break;
      if (blk_free[g]) begin
        if (has_p && p + blk_size[p] == g) begin
          blk_size[p] += s;
          blk_size[g] = 0;
          blk_free[g] = 0;
        end else begin
          has_p = 1;
          p = g;
        end
      end
      g += s;
    end
  endfunction

  function automatic bit first_fit(int unsigned req, output int unsigned where);
    int unsigned need, g, s, r;
    r = (req == 0) ? 1 : req;
    need = (r + GRANULE_BYTES - 1) / GRANULE_BYTES + HG;
    g = 0;
    where = 0;
    while (g < pool_g) begin
      s = blk_size[g];
      if (s == 0 || s > pool_g - g) break;
      if (blk_free[g] && s >= need) begin
        if (s - need >= HG + 1) begin
          blk_size[g] = need;
          blk_size[g + need] = s - need;
          blk_free[g + need] = 1;
        end
        blk_free[g] = 0;
        where = g;
        return 1;
      end
      g += s;
    end
    return 0;
  endfunction

  function automatic logic [STATUS_W-1:0] find_block(int unsigned addr,
                                                     output int unsigned where);
    int unsigned g;
    where = 0;
    if (addr >= pool_g * GRANULE_BYTES) return STATUS_OUTSIDE;
    if (addr < HB || (addr - HB) % GRANULE_BYTES != 0) return STATUS_NOT_BLOCK;
    g = (addr - HB) / GRANULE_BYTES;
    if (g >= NG || blk_size[g] == 0 || blk_free[g]) return STATUS_NOT_BLOCK;
    where = g;
    return STATUS_OK;
  endfunction

  function automatic logic [STATUS_W-1:0] release_block(int unsigned addr);
    int unsigned g;
    logic [STATUS_W-1:0] st;
    st = find_block(addr, g);
    if (st != STATUS_OK) return st;
    blk_free[g] = 1;
    merge_free();
    return STATUS_RELEASED;
  endfunction

  function automatic alloc_result_t predict_command(logic [CMD_W-1:0] cmd,
      int unsigned req, int unsigned addr, bit present);
    alloc_result_t r;
    int unsigned g, ng, need, prev_user;
    r = '0;
    if (cmd == CMD_RESET_POOL) begin
      rebuild_pool();
    end else if (cmd == CMD_ALLOC || (cmd == CMD_RESIZE && !present)) begin
      if (first_fit(req, g)) begin
        r.result_address = ADDR_W'(g * GRANULE_BYTES + HB);
        r.result_valid = 1;
      end else r.status = STATUS_NO_SPACE;
    end else if (cmd == CMD_FREE || req == 0) begin
      if (present) r.status = release_block(addr);
    end else begin
      r.status = find_block(addr, g);
      if (r.status == STATUS_OK) begin
        need = (req + GRANULE_BYTES - 1) / GRANULE_BYTES + HG;
        if (need <= blk_size[g]) begin
          r.result_address = ADDR_W'(addr);
          r.result_valid = 1;
        end else if (first_fit(req, ng)) begin
          prev_user = blk_size[g] * GRANULE_BYTES >= HB ? blk_size[g] * GRANULE_BYTES - HB : 0;
          r.copy_bytes = COPY_W'(prev_user < req ? prev_user : req);
          blk_free[g] = 1;
          merge_free();
          r.result_address = ADDR_W'(ng * GRANULE_BYTES + HB);
          r.result_valid = 1;
        end else r.status = STATUS_NO_SPACE;
      end
    end
    return r;
  endfunction

  function automatic int unsigned rand_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  task automatic send_command(logic [CMD_W-1:0] cmd, int unsigned req, int unsigned addr,
                              bit present);
    alloc_result_t r;
    repeat (rand_gap()) @(posedge clk);
    s_tdata <= {2'b0, present, addr[ADDR_W-1:0], req[REQ_W-1:0], cmd};
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    s_tvalid <= 0;
    r = predict_command(cmd, req, addr, present);
    pending_results.push_back(r);
    if (r.result_valid && (cmd == CMD_ALLOC || cmd == CMD_RESIZE))
      live_addrs.push_back(r.result_address);
    @(posedge clk);
  endtask

  task automatic write_pool_size(int unsigned bytes);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16 * NG) @(posedge clk);
    cfg_data <= bytes[CFG_W-1:0];
    cfg_we <= 1;
    @(posedge clk);
    cfg_we <= 0;
    pool_reg = bytes;
    live_addrs.delete();
    send_command(CMD_RESET_POOL, $urandom, $urandom, $urandom_range(0, 1) != 0);
  endtask

  function automatic int unsigned pick_addr();
    int unsigned k;
    if (live_addrs.size() != 0 && $urandom_range(0, 9) < 7) begin
      k = $urandom_range(0, live_addrs.size() - 1);
      pick_addr = live_addrs[k];
      live_addrs.delete(k);
    end else pick_addr = $urandom_range(0, 32767);
  endfunction

  task automatic test_directed();
    send_command(CMD_ALLOC, 0, 0, 0);
    send_command(CMD_ALLOC, 100, 32767, 1);
    send_command(CMD_ALLOC, 1048575, 0, 0);
    send_command(CMD_FREE, 0, 0, 0);
    send_command(CMD_FREE, 0, 32767, 1);
    send_command(CMD_FREE, 0, 8, 1);
    send_command(CMD_FREE, 0, HB + 4, 1);
    send_command(CMD_FREE, 0, HB, 1);
    send_command(CMD_FREE, 0, HB, 1);
    send_command(CMD_ALLOC, 8, 0, 0);
    send_command(CMD_RESIZE, 40, 0, 0);
    send_command(CMD_RESIZE, 8, HB, 1);
    send_command(CMD_RESIZE, 64, HB, 1);
    send_command(CMD_RESIZE, 1048575, HB + 32, 1);
    send_command(CMD_RESIZE, 0, HB + 64, 1);
    send_command(CMD_RESIZE, 16, 32767, 1);
    send_command(CMD_ALLOC, 32000, 0, 0);
    send_command(CMD_RESET_POOL, 1048575, 32767, 1);
    live_addrs.delete();
  endtask

  task automatic test_random(int unsigned n);
    int unsigned c, req;
    repeat (n) begin
      c = $urandom_range(0, 99);
      req = $urandom_range(0, 15) == 0 ? $urandom_range(0, 1048575) :
            $urandom_range(0, 3) == 0 ? $urandom_range(0, 2048) : $urandom_range(0, 200);
      if (c < 2) begin
        send_command(CMD_RESET_POOL, req, $urandom, $urandom_range(0, 1) != 0);
        live_addrs.delete();
      end else if (c < 45) send_command(CMD_ALLOC, req, $urandom, $urandom_range(0, 1) != 0);
      else if (c < 75) send_command(CMD_FREE, req, pick_addr(), $urandom_range(0, 19) != 0);
      else send_command(CMD_RESIZE, $urandom_range(0, 9) == 0 ? 0 : req, pick_addr(),
                        $urandom_range(0, 9) != 0);
    end
  endtask

  task automatic test_pool_sizes();
    write_pool_size(8);
    send_command(CMD_ALLOC, 0, 0, 0);
    send_command(CMD_FREE, 0, HB, 1);
    write_pool_size(0);
    send_command(CMD_ALLOC, 1, 0, 0);
    write_pool_size(33);
    send_command(CMD_ALLOC, 1, 0, 0);
    send_command(CMD_ALLOC, 1, 0, 0);
    write_pool_size(65535);
    test_random(40);
    write_pool_size(600);
    test_random(200);
    write_pool_size(32768);
  endtask

  always @(posedge clk) begin
    alloc_result_t got, want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(alloc_result_t)-1:0];
        if (pending_results.size() == 0) begin
          $display("%0t unexpected transfer, actual %h", $realtime, got);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.result_address !== want.result_address ||
              got.result_valid !== want.result_valid || got.copy_bytes !== want.copy_bytes) begin
            $display("%0t mismatch: expected st=%0d addr=%0d v=%0d copy=%0d, actual st=%0d addr=%0d v=%0d copy=%0d",
                     $realtime, want.status, want.result_address, want.result_valid,
                     want.copy_bytes, got.status, got.result_address, got.result_valid,
                     got.copy_bytes);
            errors++;
          end
        end
      end
      if (stall_out) m_tready <= ($urandom_range(0, 7) == 0);
      else m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) if ($urandom_range(0, 199) == 0) stall_out <= ~stall_out;

  initial begin
    rebuild_pool();
    repeat (4) @(posedge clk);
    rst <= 0;
    test_directed();
    test_random(220);
    test_pool_sizes();
    test_random(60);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== first_fit_pool_allocator.f =====
rtl/ffpa_pkg.sv
rtl/ffpa_table.sv
rtl/first_fit_pool_allocator.sv
tb/first_fit_pool_allocator_tb.sv
